>>> rtl/coo_to_csr_row_pointer_builder_assert.svh
// Assertion macros used by the checker file of the row-pointer builder.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef COO_TO_CSR_ROW_POINTER_BUILDER_ASSERT_SVH
`define COO_TO_CSR_ROW_POINTER_BUILDER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define C2CSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define C2CSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/c2csr_pkg.sv
// Shared types and codes of the COO-to-CSR row-pointer builder.
// Used by the sequencer, the pointer memory, the top level, the port checker and the testbench; depends on nothing.
`timescale 1ns / 1ps

package c2csr_pkg;

  localparam int unsigned OP_W        = 2;
  localparam int unsigned ROW_W       = 10;
  localparam int unsigned COLUMN_W    = 16;
  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned PIDX_W      = 11;
  localparam int unsigned PTR_W       = 17;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned ROW_COUNT_W = 11;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_FINISH = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ORDER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RESET = 11'd1024;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [ROW_W-1:0]    row;
    logic [COLUMN_W-1:0] column;
    logic [VALUE_W-1:0]  value;
    logic [PIDX_W-1:0]   pointer_index;
  } in_item_t;

  typedef struct packed {
    logic [PTR_W-1:0]    element_position;
    logic [PTR_W-1:0]    column_one_based;
    logic [VALUE_W-1:0]  value_out;
    logic [PTR_W-1:0]    pointer_value;
    logic [STATUS_W-1:0] status;
  } out_item_t;

endpackage

>>> rtl/coo_to_csr_row_pointer_builder.sv
// Builds the 1-based CSR row pointers of a matrix from row-sorted nonzero requests.
// An insert that stays in its row, a finish with no row left to fill and a
// rejected request load the result register directly when it is free; an insert
// that reaches new rows and a finish with rows left first sweep those rows of the
// pointer memory through its single write port, one entry per cycle, and a read
// of a stored entry waits for the registered read data of that memory. When the
// result register is not free, the result waits in the sequencer.
// A new request is taken whenever the sequencer is idle, even while a result
// waits downstream.
// Depends on c2csr_pkg, c2csr_ptr_ram and c2csr_seq.
`timescale 1ns / 1ps

module coo_to_csr_row_pointer_builder
  import c2csr_pkg::*;
#(
  parameter int unsigned MAX_ROWS     = 1024,
  parameter int unsigned MAX_NONZEROS = 65536
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [ROW_COUNT_W-1:0] cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  in_item_t               in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output out_item_t              out_data_o
);

  localparam int unsigned IdxW = $clog2(MAX_ROWS + 1);

  logic [ROW_COUNT_W-1:0] row_count_q;
  logic                   ram_we;
  logic [IdxW-1:0]        ram_waddr;
  logic [PTR_W-1:0]       ram_wdata;
  logic [IdxW-1:0]        ram_raddr;
  logic [PTR_W-1:0]       ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= ROW_COUNT_RESET;
    end else if (cfg_we_i) begin
      row_count_q <= cfg_wdata_i;
    end
  end

  c2csr_seq #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_NONZEROS (MAX_NONZEROS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .row_count_i (row_count_q),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  c2csr_ptr_ram #(
    .Depth (MAX_ROWS + 1)
  ) u_ptr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

>>> rtl/c2csr_ptr_ram.sv
// Row-pointer memory: one write port and one read port with registered read data.
// Depends on c2csr_pkg for the pointer width.
`timescale 1ns / 1ps

module c2csr_ptr_ram
  import c2csr_pkg::*;
#(
  parameter int unsigned Depth = 1025
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [PTR_W-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [PTR_W-1:0]         rdata_o
);

  logic [PTR_W-1:0] mem_q [Depth];
  logic [PTR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/c2csr_seq.sv
// Request sequencer: checks each request, drives the pointer-fill sweep and
// pointer reads on the memory, and holds the result register. Uses c2csr_pkg.
`timescale 1ns / 1ps

module c2csr_seq
  import c2csr_pkg::*;
#(
  parameter int unsigned MAX_ROWS     = 1024,
  parameter int unsigned MAX_NONZEROS = 65536
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [ROW_COUNT_W-1:0]          row_count_i,
  input  logic                            in_valid_i,
  input  in_item_t                        in_data_i,
  output logic                            in_stall_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output out_item_t                       out_data_o,
  output logic                            ram_we_o,
  output logic [$clog2(MAX_ROWS+1)-1:0]   ram_waddr_o,
  output logic [PTR_W-1:0]                ram_wdata_o,
  output logic [$clog2(MAX_ROWS+1)-1:0]   ram_raddr_o,
  input  logic [PTR_W-1:0]                ram_rdata_i
);

  localparam int unsigned IdxW = $clog2(MAX_ROWS + 1);
  localparam int unsigned CmpW = (IdxW > ROW_COUNT_W) ? IdxW : ROW_COUNT_W;
  localparam int unsigned CntW = $clog2(MAX_NONZEROS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_READ,
    S_HOLD
  } state_e;

  state_e            state_q;
  logic [IdxW-1:0]   next_row_q;
  logic [CntW-1:0]   count_q;
  logic              finished_q;
  logic [IdxW-1:0]   fill_addr_q;
  logic [IdxW-1:0]   fill_end_q;
  logic [PTR_W-1:0]  fill_val_q;
  out_item_t         pend_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic [CmpW-1:0]     rc_c;
  logic [CmpW-1:0]     rows_c;
  logic [CmpW-1:0]     row_c;
  logic [IdxW-1:0]     cur_next_c;
  logic [CntW-1:0]     cnt_c;
  logic [CntW-1:0]     cnt_inc_c;
  logic [CntW:0]       fin_sum_c;
  logic [STATUS_W-1:0] ins_status_c;
  logic                ins_fill_c;
  logic                fin_fill_c;
  logic                read_bad_c;
  logic                go_fill_c;
  logic                go_read_c;
  logic                accept_c;
  logic                slot_free_c;
  logic                load_out_c;
  out_item_t           res_c;

  always_comb begin
    rc_c = CmpW'(row_count_i);
    if (rc_c == '0) begin
      rows_c = CmpW'(1);
    end else if (rc_c > CmpW'(MAX_ROWS)) begin
      rows_c = CmpW'(MAX_ROWS);
    end else begin
      rows_c = rc_c;
    end
  end

  assign row_c      = CmpW'(in_data_i.row);
  assign cur_next_c = finished_q ? '0 : next_row_q;
  assign cnt_c      = finished_q ? '0 : count_q;
  assign cnt_inc_c  = cnt_c + CntW'(1);
  assign fin_sum_c  = {1'b0, count_q} + (CntW + 1)'(1);
  assign ins_fill_c = row_c >= CmpW'(cur_next_c);
  assign fin_fill_c = CmpW'(next_row_q) <= rows_c;
  assign read_bad_c = CmpW'(in_data_i.pointer_index) > CmpW'(MAX_ROWS);

  always_comb begin
    priority if (row_c + CmpW'(1) < CmpW'(cur_next_c)) begin
      ins_status_c = ST_ORDER;
    end else if (row_c >= rows_c) begin
      ins_status_c = ST_RANGE;
    end else if (cnt_c == CntW'(MAX_NONZEROS)) begin
      ins_status_c = ST_FULL;
    end else begin
      ins_status_c = ST_OK;
    end
  end

  always_comb begin
    res_c     = '0;
    go_fill_c = 1'b0;
    go_read_c = 1'b0;
    unique case (in_data_i.op)
      OP_INSERT: begin
        res_c.status = ins_status_c;
        if (ins_status_c == ST_OK) begin
          res_c.element_position = PTR_W'(cnt_inc_c);
          res_c.column_one_based = PTR_W'(in_data_i.column) + PTR_W'(1);
          res_c.value_out        = in_data_i.value;
          go_fill_c              = ins_fill_c;
        end
      end
      OP_FINISH: begin
        res_c.pointer_value = PTR_W'(count_q);
        go_fill_c           = fin_fill_c;
      end
      OP_READ: begin
        if (read_bad_c) begin
          res_c.status = ST_RANGE;
        end else begin
          go_read_c = 1'b1;
        end
      end
      default: begin
        res_c = '0;
      end
    endcase
  end

  assign accept_c    = in_valid_i && (state_q == S_IDLE);
  assign slot_free_c = !out_valid_q || !out_stall_i;
  assign load_out_c  = slot_free_c &&
                       ((accept_c && !go_fill_c && !go_read_c) || (state_q == S_HOLD));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      next_row_q  <= '0;
      count_q     <= '0;
      finished_q  <= 1'b0;
      fill_addr_q <= '0;
      fill_end_q  <= '0;
      fill_val_q  <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && !load_out_c) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept_c) begin
            pend_q <= res_c;
            if ((in_data_i.op == OP_INSERT) && (ins_status_c == ST_OK)) begin
              next_row_q  <= IdxW'(row_c + CmpW'(1));
              count_q     <= cnt_inc_c;
              finished_q  <= 1'b0;
              fill_addr_q <= cur_next_c;
              fill_end_q  <= IdxW'(row_c);
              fill_val_q  <= PTR_W'(cnt_inc_c);
            end
            if (in_data_i.op == OP_FINISH) begin
              finished_q  <= 1'b1;
              fill_addr_q <= next_row_q;
              fill_end_q  <= IdxW'(rows_c);
              fill_val_q  <= PTR_W'(fin_sum_c);
            end
            if (go_fill_c) begin
              state_q <= S_FILL;
            end else if (go_read_c) begin
              state_q <= S_READ;
            end else if (slot_free_c) begin
              out_q       <= res_c;
              out_valid_q <= 1'b1;
            end else begin
              state_q <= S_HOLD;
            end
          end
        end
        S_FILL: begin
          if (fill_addr_q == fill_end_q) begin
            state_q <= S_HOLD;
          end else begin
            fill_addr_q <= fill_addr_q + IdxW'(1);
          end
        end
        S_READ: begin
          pend_q.pointer_value <= ram_rdata_i;
          state_q              <= S_HOLD;
        end
        S_HOLD: begin
          if (slot_free_c) begin
            out_q       <= pend_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign ram_we_o    = state_q == S_FILL;
  assign ram_waddr_o = fill_addr_q;
  assign ram_wdata_o = fill_val_q;
  assign ram_raddr_o = IdxW'(in_data_i.pointer_index);

endmodule

>>> rtl/c2csr_checker.sv
// Port-level checker of the row-pointer builder, bound to the top level.
// Depends on c2csr_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "coo_to_csr_row_pointer_builder_assert.svh"

module c2csr_checker
  import c2csr_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 1024
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  `C2CSR_ASSERT_NEXT(a_out_valid_held, out_valid_o && out_stall_i, out_valid_o, "stalled result dropped")
  `C2CSR_ASSERT_NEXT(a_out_data_held, out_valid_o && out_stall_i, $stable(out_data_o), "stalled result changed")
  `C2CSR_ASSERT_NOW(a_element_ok, out_valid_o && (out_data_o.element_position != '0), (out_data_o.status == ST_OK) && (out_data_o.column_one_based != '0), "element result with error status")
  `C2CSR_ASSERT_NEXT(a_read_busy, in_valid_i && !in_stall_o && (in_data_i.op == OP_READ) && ({21'd0, in_data_i.pointer_index} <= 32'(MAX_ROWS)), in_stall_o, "pointer read did not occupy the block")

endmodule

bind coo_to_csr_row_pointer_builder c2csr_checker #(.MAX_ROWS(MAX_ROWS)) u_c2csr_checker (.*);

>>> test/tb_top.sv
// Self-checking testbench for coo_to_csr_row_pointer_builder.
// It drives a directed table and runs random matrices, checking every
// response against the table or a CSR predictor. Depends on c2csr_pkg.
`timescale 1ns / 1ps

module tb_top;
  import c2csr_pkg::*;

  localparam int unsigned ROWS_MAX     = 1024;
  localparam int unsigned NONZEROS_MAX = 65536;
  localparam int unsigned PIDX_TOP     = 2 ** PIDX_W - 1;
  localparam int unsigned CYCLE_LIMIT  = 5000000;
  localparam int unsigned HOLD_CYCLES  = 250;

  localparam logic [OP_W-1:0]    OP_IGNORED = 2'd3;
  localparam logic [VALUE_W-1:0] ONES64     = '1;

  localparam out_item_t RANGE_ERR = '{17'd0, 17'd0, 64'd0, 17'd0, ST_RANGE};
  localparam out_item_t ORDER_ERR = '{17'd0, 17'd0, 64'd0, 17'd0, ST_ORDER};
  localparam out_item_t UNCHECKED = '0;

  typedef enum logic {STEP_REQUEST, STEP_ROW_COUNT} step_kind_e;

  typedef struct packed {
    step_kind_e             kind;
    logic [OP_W-1:0]        op;
    logic [ROW_W-1:0]       row;
    logic [COLUMN_W-1:0]    column;
    logic [VALUE_W-1:0]     value;
    logic [PIDX_W-1:0]      pidx;
    logic [ROW_COUNT_W-1:0] rows;
    bit                     fixed;
    out_item_t              want;
  } step_t;

  localparam step_t DIRECTED_STEPS [28] = '{
    '{STEP_REQUEST, OP_READ, 10'd0, 16'd0, 64'd0, 11'd1025, 11'd0, 1'b1, RANGE_ERR},
    '{STEP_REQUEST, OP_READ, 10'd0, 16'd0, 64'd0, 11'd2047, 11'd0, 1'b1, RANGE_ERR},
    '{STEP_REQUEST, OP_IGNORED, 10'd1023, 16'hFFFF, ONES64, 11'd2047, 11'd0, 1'b1, '0},
    '{STEP_REQUEST, OP_INSERT, 10'd0, 16'd0, 64'd0, 11'd0, 11'd0, 1'b1,
      '{17'd1, 17'd1, 64'd0, 17'd0, ST_OK}},
    '{STEP_REQUEST, OP_INSERT, 10'd0, 16'hFFFF, ONES64, 11'd0, 11'd0, 1'b1,
      '{17'd2, 17'd65536, ONES64, 17'd0, ST_OK}},
    '{STEP_REQUEST, OP_INSERT, 10'd3, 16'd7, 64'h0123_4567_89AB_CDEF, 11'd0, 11'd0, 1'b0,
      UNCHECKED},
    '{STEP_REQUEST, OP_INSERT, 10'd2, 16'd9, 64'd5, 11'd0, 11'd0, 1'b1, ORDER_ERR},
    '{STEP_REQUEST, OP_READ, 10'd0, 16'd0, 64'd0, 11'd0, 11'd0, 1'b1,
      '{17'd0, 17'd0, 64'd0, 17'd1, ST_OK}},
    '{STEP_REQUEST, OP_READ, 10'd0, 16'd0, 64'd0, 11'd2, 11'd0, 1'b0, UNCHECKED},
    '{STEP_REQUEST, OP_INSERT, 10'd1023, 16'h5A5A, 64'hFEDC_BA98_7654_3210, 11'd0, 11'd0,
      1'b0, UNCHECKED},
    '{STEP_REQUEST, OP_FINISH, 10'd0, 16'd0, 64'd0, 11'd0, 11'd0, 1'b1,
      '{17'd0, 17'd0, 64'd0, 17'd4, ST_OK}},
    '{STEP_REQUEST, OP_READ, 10'd0, 16'd0, 64'd0, 11'd1024, 11'd0, 1'b0, UNCHECKED},
    '{STEP_REQUEST, OP_FINISH, 10'd0, 16'd0, 64'd0, 11'd0, 11'd0, 1'b1,
      '{17'd0, 17'd0, 64'd0, 17'd4, ST_OK}},
    '{STEP_REQUEST, OP_INSERT, 10'd5, 16'd11, 64'hAAAA_5555_AAAA_5555, 11'd0, 11'd0, 1'b0,
      UNCHECKED},
    '{STEP_ROW_COUNT, OP_INSERT, 10'd0, 16'd0, 64'd0, 11'd0, 11'd2, 1'b0, UNCHECKED},
    '{STEP_REQUEST, OP_FINISH, 10'd0, 16'd0, 64'd0, 11'd0, 11'd0, 1'b1,
      '{17'd0, 17'd0, 64'd0, 17'd1, ST_OK}},
    '{STEP_REQUEST, OP_INSERT, 10'd2, 16'd1, 64'd1, 11'd0, 11'd0, 1'b1, RANGE_ERR},
    '{STEP_REQUEST, OP_INSERT, 10'd0, 16'd3, 64'h8000_0000_0000_0001, 11'd0, 11'd0, 1'b1,
      '{17'd1, 17'd4, 64'h8000_0000_0000_0001, 17'd0, ST_OK}},
    '{STEP_ROW_COUNT, OP_INSERT, 10'd0, 16'd0, 64'd0, 11'd0, 11'd1, 1'b0, UNCHECKED},
    '{STEP_REQUEST, OP_INSERT, 10'd1, 16'd2, 64'd2, 11'd0, 11'd0, 1'b1, RANGE_ERR},
    '{STEP_REQUEST, OP_FINISH, 10'd0, 16'd0, 64'd0, 11'd0, 11'd0, 1'b1,
      '{17'd0, 17'd0, 64'd0, 17'd1, ST_OK}},
    '{STEP_REQUEST, OP_READ, 10'd0, 16'd0, 64'd0, 11'd1, 11'd0, 1'b0, UNCHECKED},
    '{STEP_ROW_COUNT, OP_INSERT, 10'd0, 16'd0, 64'd0, 11'd0, 11'd0, 1'b0, UNCHECKED},
    '{STEP_REQUEST, OP_INSERT, 10'd1, 16'd2, 64'd2, 11'd0, 11'd0, 1'b1, RANGE_ERR},
    '{STEP_ROW_COUNT, OP_INSERT, 10'd0, 16'd0, 64'd0, 11'd0, 11'd2047, 1'b0, UNCHECKED},
    '{STEP_REQUEST, OP_INSERT, 10'd1023, 16'hFFFF, 64'h7FFF_FFFF_FFFF_FFFE, 11'd0, 11'd0,
      1'b0, UNCHECKED},
    '{STEP_REQUEST, OP_FINISH, 10'd0, 16'd0, 64'd0, 11'd0, 11'd0, 1'b0, UNCHECKED},
    '{STEP_REQUEST, OP_READ, 10'd0, 16'd0, 64'd0, 11'd1024, 11'd0, 1'b0, UNCHECKED}
  };

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic [ROW_COUNT_W-1:0] cfg_wdata_i = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  in_item_t               in_data_i   = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  out_item_t              out_data_o;

  logic [ROW_COUNT_W-1:0] csr_rows_cfg = ROW_COUNT_RESET;
  int                     csr_row      = -1;
  int unsigned            csr_count    = 0;
  bit                     csr_done     = 1'b0;
  int                     csr_ptr_hi   = -1;
  logic [PTR_W-1:0]       csr_ptr [0:ROWS_MAX];

  out_item_t   csr_results_q [$];
  int unsigned request_count   = 0;
  int unsigned mismatch_count  = 0;
  int unsigned cycle_count     = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct       = 0;
  logic        hold_request    = 1'b0;
  logic        hold_active     = 1'b0;

  coo_to_csr_row_pointer_builder #(
    .MAX_ROWS    (ROWS_MAX),
    .MAX_NONZEROS(NONZEROS_MAX)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_rows(input logic [ROW_COUNT_W-1:0] cfg);
    if (cfg == 0) return 1;
    if (cfg > ROWS_MAX) return ROWS_MAX;
    return cfg;
  endfunction

  function automatic out_item_t predict_csr_response(input in_item_t req);
    out_item_t   res;
    int unsigned rows;
    int          cur;
    int unsigned cnt;
    res = '0;
    rows = eff_rows(csr_rows_cfg);
    if (req.op == OP_INSERT) begin
      cur = csr_done ? -1 : csr_row;
      cnt = csr_done ? 0 : csr_count;
      if (int'(req.row) < cur) begin
        res.status = ST_ORDER;
      end else if (req.row >= rows) begin
        res.status = ST_RANGE;
      end else if (cnt >= NONZEROS_MAX) begin
        res.status = ST_FULL;
      end else begin
        while (cur < int'(req.row)) begin
          cur = cur + 1;
          csr_ptr[cur] = PTR_W'(cnt + 1);
        end
        cnt = cnt + 1;
        csr_row = cur;
        csr_count = cnt;
        csr_done = 1'b0;
        if (cur > csr_ptr_hi) csr_ptr_hi = cur;
        res.element_position = PTR_W'(cnt);
        res.column_one_based = {1'b0, req.column} + 17'd1;
        res.value_out = req.value;
      end
    end else if (req.op == OP_FINISH) begin
      for (int k = csr_row + 1; k <= int'(rows); k++) begin
        csr_ptr[k] = PTR_W'(csr_count + 1);
      end
      if (int'(rows) > csr_ptr_hi) csr_ptr_hi = rows;
      csr_done = 1'b1;
      res.pointer_value = PTR_W'(csr_count);
    end else if (req.op == OP_READ) begin
      if (req.pointer_index > ROWS_MAX) res.status = ST_RANGE;
      else res.pointer_value = csr_ptr[req.pointer_index];
    end
    return res;
  endfunction

  function automatic in_item_t random_bits();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t noise_request(input int unsigned rows);
    in_item_t req;
    req = random_bits();
    req.op = OP_READ;
    req.pointer_index = PIDX_W'($urandom_range(ROWS_MAX + 1, PIDX_TOP));
    case ($urandom_range(0, 4))
      0: begin
        req.op = OP_IGNORED;
      end
      1: begin
        if (rows < ROWS_MAX) begin
          req.op = OP_INSERT;
          req.row = ROW_W'($urandom_range(rows, ROWS_MAX - 1));
        end
      end
      2: begin
        if (!csr_done && csr_row > 0) begin
          req.op = OP_INSERT;
          req.row = ROW_W'($urandom_range(0, csr_row - 1));
        end
      end
      default: begin
        if (csr_ptr_hi >= 0) req.pointer_index = PIDX_W'($urandom_range(0, csr_ptr_hi));
      end
    endcase
    return req;
  endfunction

  task automatic send_request(input in_item_t req, input bit fixed = 1'b0,
                              input out_item_t want = '0);
    bit lowered;
    lowered = 1'b0;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      if (!lowered) in_valid_i <= 1'b0;
      lowered = 1'b1;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    want = fixed ? want : predict_csr_response(req);
    if (fixed) void'(predict_csr_response(req));
    csr_results_q.push_back(want);
    if (req.op != OP_IGNORED) request_count++;
  endtask

  task automatic drain_responses();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (csr_results_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_row_count(input logic [ROW_COUNT_W-1:0] cfg);
    drain_responses();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cfg;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    csr_rows_cfg = cfg;
  endtask

  task automatic random_matrix(input int unsigned inserts, input bit hold);
    in_item_t               req;
    logic [ROW_COUNT_W-1:0] cfg;
    int unsigned            rows;
    int                     r;
    int                     step;
    case ($urandom_range(0, 9))
      0: cfg = 11'd1;
      1: cfg = ROW_COUNT_RESET;
      2: cfg = $urandom_range(0, 1) ? 11'd0 : 11'd2047;
      default: cfg = ROW_COUNT_W'($urandom_range(2, 48));
    endcase
    write_row_count(cfg);
    if (hold) hold_request <= 1'b1;
    rows = eff_rows(cfg);
    r = (csr_done || csr_row < 0) ? 0 : csr_row;
    for (int n = 0; n < int'(inserts); n++) begin
      if ($urandom_range(0, 99) < 20) send_request(noise_request(rows));
      if ($urandom_range(0, 9) < 6) step = 0;
      else if ($urandom_range(0, 3) == 0) step = $urandom_range(2, 5);
      else step = 1;
      if (r + step < int'(rows)) r = r + step;
      req = random_bits();
      req.op = OP_INSERT;
      req.row = ROW_W'(r);
      send_request(req);
    end
    if ($urandom_range(0, 7) != 0) begin
      req = random_bits();
      req.op = OP_FINISH;
      send_request(req);
      if ($urandom_range(0, 5) == 0) send_request(req);
    end
    repeat ($urandom_range(1, 3)) begin
      req = random_bits();
      req.op = OP_READ;
      if (csr_ptr_hi < 0) req.pointer_index = PIDX_W'(ROWS_MAX + 1);
      else req.pointer_index = PIDX_W'($urandom_range(0, csr_ptr_hi));
      send_request(req);
    end
  endtask

  initial begin
    wait (hold_request);
    @(posedge clk_i);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_active <= 1'b0;
  end

  always @(posedge clk_i) begin
    out_item_t want;
    out_stall_i <= hold_active || ($urandom_range(0, 99) < stall_pct);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (csr_results_q.size() == 0) begin
        $error("response with no request pending: %h", out_data_o);
        mismatch_count++;
      end else begin
        want = csr_results_q.pop_front();
        if (out_data_o !== want) mismatch_count++;
        if (out_data_o.element_position !== want.element_position)
          $error("element_position: expected %0d, actual %0d",
                 want.element_position, out_data_o.element_position);
        if (out_data_o.column_one_based !== want.column_one_based)
          $error("column_one_based: expected %0d, actual %0d",
                 want.column_one_based, out_data_o.column_one_based);
        if (out_data_o.value_out !== want.value_out)
          $error("value_out: expected %h, actual %h", want.value_out, out_data_o.value_out);
        if (out_data_o.pointer_value !== want.pointer_value)
          $error("pointer_value: expected %0d, actual %0d",
                 want.pointer_value, out_data_o.pointer_value);
        if (out_data_o.status !== want.status)
          $error("status: expected %0d, actual %0d", want.status, out_data_o.status);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("coo_to_csr_row_pointer_builder: mismatch");
      $finish;
    end
  end

  initial begin
    in_item_t    req;
    int unsigned phase_start;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_STEPS[i]) begin
      if (DIRECTED_STEPS[i].kind == STEP_ROW_COUNT) begin
        write_row_count(DIRECTED_STEPS[i].rows);
      end else begin
        req = {DIRECTED_STEPS[i].op, DIRECTED_STEPS[i].row, DIRECTED_STEPS[i].column,
               DIRECTED_STEPS[i].value, DIRECTED_STEPS[i].pidx};
        send_request(req, DIRECTED_STEPS[i].fixed, DIRECTED_STEPS[i].want);
      end
    end

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin sender_idle_pct = 0;  stall_pct <= 0;  end
        1: begin sender_idle_pct = 69; stall_pct <= 0;  end
        2: begin sender_idle_pct = 0;  stall_pct <= 69; end
        default: begin sender_idle_pct = 37; stall_pct <= 37; end
      endcase
      phase_start = request_count;
      if (p == 0) random_matrix(40, 1'b1);
      while (request_count - phase_start < 100) random_matrix($urandom_range(1, 20), 1'b0);
    end

    drain_responses();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("coo_to_csr_row_pointer_builder: match");
    end else begin
      $display("coo_to_csr_row_pointer_builder: mismatch");
    end
    $finish;
  end

endmodule
